FILE: sv/median_filter_3x3_top_defines.svh
`ifndef MEDIAN_FILTER_3X3_TOP_DEFINES_SVH
`define MEDIAN_FILTER_3X3_TOP_DEFINES_SVH

// same-cycle implication, masked while reset is high
`define MF3_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked while reset is high
`define MF3_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers the reset cycles
`define MF3_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/mf3_pkg.sv
`default_nettype none

package mf3_pkg;

   // pixel and window geometry
   localparam int PIX_W       = 8;
   localparam int WIN_SIDE    = 3;
   localparam int WIN_CELLS   = 9;
   localparam int MEDIAN_RANK = 4;
   localparam int NET_IDX_W   = $clog2(WIN_CELLS);

   // counters and register fields
   localparam int ROW_W        = 12;
   localparam int IMG_W_W      = 11;
   localparam int IMG_H_W      = 13;
   localparam int HEIGHT_CAP   = 4096;
   localparam int IMG_W_RESET  = 1024;
   localparam int IMG_H_RESET  = 1024;
   localparam int MAX_LINE_DEF = 1024;

   // control register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LINE_LEN   = 2'd0,
      REG_LINE_COUNT = 2'd1
   } csr_reg_type;

   typedef logic [PIX_W-1:0] pix_type;

   // one window column: element 0 is the oldest line, element 2 the current line
   typedef pix_type [WIN_SIDE-1:0] col_type;

   // full window, row-major, index 3*row + column
   typedef pix_type [WIN_CELLS-1:0] win_type;

   // per-item control that travels with the data
   typedef struct packed {
      logic emit;
      logic last;
   } tag_type;

   // median-of-nine exchange network, in dependency order
   localparam int NET_OPS = 19;
   localparam int SPLIT_A = 9;
   localparam int SPLIT_B = 15;

   localparam logic [NET_IDX_W-1:0] NET_LO [NET_OPS] = '{
      4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
      4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
   };
   localparam logic [NET_IDX_W-1:0] NET_HI [NET_OPS] = '{
      4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
      4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
   };

   // apply exchanges first .. stop-1; the smaller value lands on the NET_LO index
   function automatic win_type compare_exchange(win_type w_in, int first, int stop);
      win_type w;
      pix_type lo_v;
      pix_type hi_v;
      int      i;
      w = w_in;
      for (i = first; i < stop; i++) begin
         lo_v = w[NET_LO[i]];
         hi_v = w[NET_HI[i]];
         if (lo_v > hi_v) begin
            w[NET_LO[i]] = hi_v;
            w[NET_HI[i]] = lo_v;
         end
      end
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: sv/mf3_channel_if.sv
`default_nettype none

// pixel stream channel
interface mf3_pixel_if;
   import mf3_pkg::*;
   logic    valid;
   logic    ready;
   pix_type pixel;
   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

// median result channel
interface mf3_result_if;
   import mf3_pkg::*;
   logic    valid;
   logic    ready;
   pix_type median;
   logic    frame_last;
   modport source (output valid, output median, output frame_last, input ready);
   modport sink (input valid, input median, input frame_last, output ready);
endinterface

// control register write channel
interface mf3_csr_if;
   import mf3_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/mf3_ram.sv
`default_nettype none

module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: sv/mf3_col_cell.sv
`default_nettype none

module mf3_col_cell (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire mf3_pkg::col_type col_in,
   output      mf3_pkg::col_type col_out
);
   import mf3_pkg::*;

   col_type col_ff;

   // take the column from the right-hand neighbor on each shift
   always_ff @(posedge clock) begin
      if (enable) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

`default_nettype wire

FILE: sv/mf3_median.sv
`default_nettype none

module mf3_median (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             enable,
   input  wire mf3_pkg::win_type win,
   input  wire mf3_pkg::tag_type tag_in,
   output      mf3_pkg::pix_type median,
   output      mf3_pkg::tag_type tag_out
);
   import mf3_pkg::*;

   win_type win_a_ff;
   win_type win_b_ff;
   win_type win_c;
   pix_type median_ff;
   tag_type tag_a_ff;
   tag_type tag_b_ff;
   tag_type tag_c_ff;

   // last group of exchanges feeds the output register
   assign win_c = compare_exchange(win_b_ff, SPLIT_B, NET_OPS);

   // three network stages, frozen together while the output stalls
   always_ff @(posedge clock) begin
      if (enable) begin
         win_a_ff  <= compare_exchange(win, 0, SPLIT_A);
         win_b_ff  <= compare_exchange(win_a_ff, SPLIT_A, SPLIT_B);
         median_ff <= win_c[MEDIAN_RANK];
      end
   end

   // item tags follow the data
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
         tag_c_ff <= '0;
      end else if (enable) begin
         tag_a_ff <= tag_in;
         tag_b_ff <= tag_a_ff;
         tag_c_ff <= tag_b_ff;
      end
   end

   assign median  = median_ff;
   assign tag_out = tag_c_ff;

endmodule

`default_nettype wire

FILE: sv/median_filter_3x3_top.sv
// 3x3 median filter over an 8-bit grayscale pixel stream in raster order.
// req_if carries one pixel per transfer; rsp_if carries one median per interior
// pixel, with frame_last high on the final median of the frame. Border
// centres give no transfer on rsp_if.
// csr_if writes the line length (index 0) and the lines per frame (index 1);
// values clamp to [3, MAX_LINE] and [3, 4096]; either write restarts the frame.
// Throughput: one pixel per clock while rsp_if does not stall. The rate is set
// by the line store RAMs, each read once and written once per pixel, and by a
// three-stage exchange network for the median.
// Path: a median reaches rsp_if from the transfer of the pixel that completes
// its window through the read stage, the window shift and three network stages,
// the last of which is the output register.
// Stall: while rsp_if holds a result that is not taken, the whole pipeline
// freezes and req_if.ready drops in the same cycle; otherwise req_if stays
// ready even with a result waiting.
// Reset: counters go to zero, width and height to 1024 (width clamped to
// MAX_LINE), no result is pending. The line stores are not cleared; the
// first two lines of a frame never produce output.
`default_nettype none

module median_filter_3x3_top #(
   parameter int MAX_LINE = mf3_pkg::MAX_LINE_DEF
) (
   input wire logic       clock,
   input wire logic       reset,
   mf3_pixel_if.sink      req_if,
   mf3_result_if.source   rsp_if,
   mf3_csr_if.sink        csr_if
);
   import mf3_pkg::*;

   localparam int COL_W   = $clog2(MAX_LINE);
   localparam int W_RESET = (IMG_W_RESET > MAX_LINE) ? MAX_LINE : IMG_W_RESET;

   logic               advance;
   logic               accept;
   logic               csr_write;
   logic               shift;
   logic [IMG_W_W-1:0] cfg_w;
   logic [IMG_H_W-1:0] cfg_h;
   logic [COL_W-1:0]   wlast_clamp;
   logic [ROW_W-1:0]   hlast_clamp;
   tag_type            tag_now;

   logic [COL_W-1:0]   col_ff;
   logic [COL_W-1:0]   col_in;
   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   row_in;
   logic [COL_W-1:0]   wlast_ff;
   logic [COL_W-1:0]   wlast_in;
   logic [ROW_W-1:0]   hlast_ff;
   logic [ROW_W-1:0]   hlast_in;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   pix_type            s1_pixel_ff;
   logic [COL_W-1:0]   s1_col_ff;
   tag_type            s1_tag_ff;
   tag_type            tag_w_ff;
   tag_type            tag_w_in;

   pix_type            up_rd;
   pix_type            mid_rd;
   col_type            new_col;
   col_type            cell_in  [WIN_SIDE];
   col_type            cell_out [WIN_SIDE];
   win_type            win;
   pix_type            med_pix;
   tag_type            med_tag;

   // handshakes: the pipeline moves unless a result is stuck at the output
   assign advance       = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready  = advance && !reset;
   assign csr_if.ready  = !reset;
   assign accept        = req_if.valid && req_if.ready;
   assign csr_write     = csr_if.valid && csr_if.ready;
   assign shift         = advance && s1_valid_ff;

   // clamp register writes to the supported range
   assign cfg_w = csr_if.data[IMG_W_W-1:0];
   assign cfg_h = csr_if.data[IMG_H_W-1:0];

   always_comb begin
      if (cfg_w < IMG_W_W'(WIN_SIDE)) begin
         wlast_clamp = COL_W'(WIN_SIDE - 1);
      end else if (int'(cfg_w) > MAX_LINE) begin
         wlast_clamp = COL_W'(MAX_LINE - 1);
      end else begin
         wlast_clamp = COL_W'(cfg_w - IMG_W_W'(1));
      end
      if (cfg_h < IMG_H_W'(WIN_SIDE)) begin
         hlast_clamp = ROW_W'(WIN_SIDE - 1);
      end else if (int'(cfg_h) > HEIGHT_CAP) begin
         hlast_clamp = ROW_W'(HEIGHT_CAP - 1);
      end else begin
         hlast_clamp = ROW_W'(cfg_h - IMG_H_W'(1));
      end
   end

   // interior test and end-of-frame flag for the pixel being taken
   assign tag_now.emit = (row_ff >= ROW_W'(WIN_SIDE - 1)) && (col_ff >= COL_W'(WIN_SIDE - 1));
   assign tag_now.last = (row_ff == hlast_ff) && (col_ff == wlast_ff);

   // raster counters and frame size
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      wlast_in = wlast_ff;
      hlast_in = hlast_ff;
      if (csr_write) begin
         case (csr_if.index)
            REG_LINE_LEN: begin
               wlast_in = wlast_clamp;
               col_in   = '0;
               row_in   = '0;
            end
            REG_LINE_COUNT: begin
               hlast_in = hlast_clamp;
               col_in   = '0;
               row_in   = '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (col_ff == wlast_ff) begin
            col_in = '0;
            row_in = (row_ff == hlast_ff) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // stage tags: only transferred pixels shift the window
   assign s1_valid_in = accept;
   assign tag_w_in    = s1_valid_ff ? s1_tag_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         wlast_ff    <= COL_W'(W_RESET - 1);
         hlast_ff    <= ROW_W'(IMG_H_RESET - 1);
         s1_valid_ff <= 1'b0;
         tag_w_ff    <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         wlast_ff <= wlast_in;
         hlast_ff <= hlast_in;
         if (advance) begin
            s1_valid_ff <= s1_valid_in;
            tag_w_ff    <= tag_w_in;
         end
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pixel_ff <= req_if.pixel;
         s1_col_ff   <= col_ff;
         s1_tag_ff   <= tag_now;
      end
   end

   // line stores: read at transfer, rotate lines one stage later
   mf3_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_LINE)
   ) u_upper_ram (
      .clock (clock),
      .we    (shift),
      .waddr (s1_col_ff),
      .wdata (mid_rd),
      .re    (advance),
      .raddr (col_ff),
      .rdata (up_rd)
   );

   mf3_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_LINE)
   ) u_middle_ram (
      .clock (clock),
      .we    (shift),
      .waddr (s1_col_ff),
      .wdata (s1_pixel_ff),
      .re    (advance),
      .raddr (col_ff),
      .rdata (mid_rd)
   );

   // newest column enters at the right end of the cell row
   always_comb begin
      new_col[0] = up_rd;
      new_col[1] = mid_rd;
      new_col[2] = s1_pixel_ff;
   end

   for (genvar k = 0; k < WIN_SIDE; k++) begin : g_cell
      if (k == WIN_SIDE - 1) begin : g_head
         assign cell_in[k] = new_col;
      end else begin : g_link
         assign cell_in[k] = cell_out[k+1];
      end

      mf3_col_cell u_cell (
         .clock   (clock),
         .enable  (shift),
         .col_in  (cell_in[k]),
         .col_out (cell_out[k])
      );
   end

   // gather the cells into a row-major window
   always_comb begin
      for (int r = 0; r < WIN_SIDE; r++) begin
         for (int c = 0; c < WIN_SIDE; c++) begin
            win[WIN_SIDE*r + c] = cell_out[c][r];
         end
      end
   end

   // median network; its last stage is the output register
   mf3_median u_median (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance),
      .win     (win),
      .tag_in  (tag_w_ff),
      .median  (med_pix),
      .tag_out (med_tag)
   );

   assign rsp_if.valid      = med_tag.emit;
   assign rsp_if.median     = med_pix;
   assign rsp_if.frame_last = med_tag.last;

endmodule

`default_nettype wire

FILE: sv/mf3_checker.sv
`default_nettype none
`include "median_filter_3x3_top_defines.svh"

module mf3_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire mf3_pkg::pix_type median,
   input wire logic             frame_last
);

   // a result that is not taken stays put
   `MF3_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(median) && $stable(frame_last), "rsp payload changed under stall")

   // nothing pending right after reset
   `MF3_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid, "result pending after reset")

   // with the output empty the block takes pixels
   `MF3_ASSERT_IMPLY(a_ready_empty, !rsp_valid, req_ready, "req not ready with empty output")

   // a result leaving frees the pipeline in the same cycle
   `MF3_ASSERT_IMPLY(a_ready_drain, rsp_valid && rsp_ready, req_ready, "req not ready while rsp drains")

endmodule

bind median_filter_3x3_top mf3_checker u_mf3_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .median     (rsp_if.median),
   .frame_last (rsp_if.frame_last)
);

`default_nettype wire

FILE: tb/median_filter_3x3_top_tb.sv
`default_nettype none

module median_filter_3x3_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mf3_pkg::*;

   localparam int MAX_LINE      = MAX_LINE_DEF;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 10;
   localparam int RANDOM_ITEMS  = 1100;

   // register indexes the block does not implement
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;

   typedef struct packed {
      pix_type median;
      logic    frame_last;
   } median_result_type;

   // pixel content styles
   typedef enum int {FILL_UNIFORM, FILL_EXTREMES, FILL_BAND} fill_kind_type;

   // mirror of the filter state and queue of medians still to come
   class median_tracker_type;
      int unsigned       width_reg;
      int unsigned       height_reg;
      int unsigned       col;
      int unsigned       row;
      int unsigned       errors;
      pix_type           upper_line [MAX_LINE];
      pix_type           middle_line [MAX_LINE];
      pix_type           win [WIN_CELLS];
      median_result_type medians_due [$];

      function new();
         width_reg  = IMG_W_RESET;
         height_reg = IMG_H_RESET;
         col        = 0;
         row        = 0;
         errors     = 0;
         foreach (win[i]) win[i] = '0;
         foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
      endfunction

      // a width or height write restarts the frame; other indexes do nothing
      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == REG_LINE_LEN) begin
            width_reg = data[IMG_W_W-1:0];
            col       = 0;
            row       = 0;
         end else if (idx == REG_LINE_COUNT) begin
            height_reg = data[IMG_H_W-1:0];
            col        = 0;
            row        = 0;
         end
      endfunction

      // fifth smallest of the window
      function pix_type window_median();
         pix_type v [WIN_CELLS];
         pix_type key;
         int      i;
         int      j;
         v = win;
         for (i = 1; i < WIN_CELLS; i++) begin
            key = v[i];
            j   = i;
            while (j > 0 && v[j-1] > key) begin
               v[j] = v[j-1];
               j--;
            end
            v[j] = key;
         end
         return v[MEDIAN_RANK];
      endfunction

      function void take_pixel(pix_type px);
         int unsigned       w;
         int unsigned       h;
         int unsigned       c;
         int unsigned       r;
         int                k;
         median_result_type res;
         // clamp the geometry
         w = (width_reg < WIN_SIDE) ? WIN_SIDE : (width_reg > MAX_LINE) ? MAX_LINE : width_reg;
         h = (height_reg < WIN_SIDE) ? WIN_SIDE :
             (height_reg > HEIGHT_CAP) ? HEIGHT_CAP : height_reg;
         c = (col >= w) ? 0 : col;
         r = (row >= h) ? 0 : row;
         // shift the window left and load the new column
         for (k = 0; k < WIN_SIDE; k++) begin
            win[k*WIN_SIDE]     = win[k*WIN_SIDE + 1];
            win[k*WIN_SIDE + 1] = win[k*WIN_SIDE + 2];
         end
         win[2] = upper_line[c];
         win[5] = middle_line[c];
         win[8] = px;
         upper_line[c]  = middle_line[c];
         middle_line[c] = px;
         // interior centres only
         if (r >= 2 && c >= 2) begin
            res.median     = window_median();
            res.frame_last = (r == h - 1 && c == w - 1);
            medians_due.push_back(res);
         end
         c++;
         if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
         end
         col = c;
         row = r;
      endfunction

      function void check_median(pix_type m, logic fl);
         median_result_type want;
         if (medians_due.size() == 0) begin
            errors++;
            $display("%0t: median %0d frame_last %0b arrived with none expected",
                     $time, m, fl);
         end else begin
            want = medians_due.pop_front();
            if (m !== want.median) begin
               errors++;
               $display("%0t: median expected %0d actual %0d", $time, want.median, m);
            end
            if (fl !== want.frame_last) begin
               errors++;
               $display("%0t: frame_last expected %0b actual %0b",
                        $time, want.frame_last, fl);
            end
         end
      endfunction

      function int pending();
         return medians_due.size();
      endfunction

      function void drop_leftover();
         errors += medians_due.size();
         $display("%0t: %0d medians never arrived", $time, medians_due.size());
         medians_due.delete();
      endfunction
   endclass

   logic clock;
   logic reset;

   mf3_pixel_if  req_if ();
   mf3_result_if rsp_if ();
   mf3_csr_if    csr_if ();

   median_tracker_type tracker = new();
   int                 burst_left = 0;
   bit                 gaps_on = 1'b0;
   int unsigned        random_sent = 0;

   median_filter_3x3_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop
   initial begin
      #50_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side: check each transfer, ready follows a rotating stall pattern
   initial begin
      logic [15:0] stall_pattern;
      int          stall_hold;
      stall_pattern = '1;
      stall_hold    = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            tracker.check_median(rsp_if.median, rsp_if.frame_last);
         if (stall_hold <= 0) begin
            stall_hold = $urandom_range(600, 40);
            case ($urandom_range(3, 0))
               0: stall_pattern = '1;
               1: stall_pattern = 16'($urandom) | 16'h1;
               2: stall_pattern = 16'($urandom & $urandom) | 16'h1;
               default: stall_pattern = 16'($urandom | $urandom) | 16'h1;
            endcase
         end
         stall_hold--;
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         rsp_if.ready <= stall_pattern[0];
      end
   end

   // one pixel transfer, with bursts and gaps when enabled
   task automatic send_pixel(pix_type p);
      if (gaps_on && burst_left <= 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = $urandom_range(32, 1);
      end
      req_if.valid <= 1'b1;
      req_if.pixel <= p;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      tracker.take_pixel(p);
      burst_left--;
   endtask

   task automatic send_block(int n, fill_kind_type fill);
      pix_type base;
      pix_type p;
      int      i;
      base = pix_type'($urandom);
      for (i = 0; i < n; i++) begin
         case (fill)
            FILL_EXTREMES: p = $urandom_range(1, 0) ? 8'hFF : 8'h00;
            FILL_BAND:     p = base + pix_type'($urandom_range(3, 0));
            default:       p = pix_type'($urandom_range(255, 0));
         endcase
         send_pixel(p);
      end
   endtask

   // stop the stream, let all medians out, then let the pipeline empty
   task automatic settle();
      int k;
      req_if.valid <= 1'b0;
      for (k = 0; k < DRAIN_LIMIT && tracker.pending() != 0; k++) @(posedge clock);
      if (tracker.pending() != 0) tracker.drop_leftover();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register transfer; more keeps valid high for a following write
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data, bit more);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      tracker.write_register(idx, data);
      if (!more) csr_if.valid <= 1'b0;
   endtask

   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned frame;
      int unsigned n;
      int          i;

      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.pixel <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= REG_LINE_LEN;
      csr_if.data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // a few pixels at the reset geometry, top rows give nothing
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h80);
      send_pixel(8'h7F);
      settle();

      // smallest frame: checkerboard of extremes, then ties
      write_csr(REG_LINE_LEN, 16'd3, 1'b1);
      write_csr(REG_LINE_COUNT, 16'd3, 1'b0);
      for (i = 0; i < WIN_CELLS; i++) send_pixel((i % 2) ? 8'h00 : 8'hFF);
      send_pixel(8'd7);
      send_pixel(8'd7);
      send_pixel(8'd7);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'd7);
      send_pixel(8'hFF);
      send_pixel(8'h00);
      send_pixel(8'd7);
      settle();

      // register values below the minimum clamp to three
      gaps_on = 1'b1;
      write_csr(REG_LINE_LEN, 16'd0, 1'b1);
      write_csr(REG_LINE_COUNT, 16'd0, 1'b0);
      send_block(18, FILL_UNIFORM);
      settle();

      // all-ones width clamps to the longest line
      write_csr(REG_LINE_LEN, 16'd2047, 1'b1);
      write_csr(REG_LINE_COUNT, 16'd3, 1'b0);
      send_block(48, FILL_UNIFORM);
      settle();

      // all-ones height clamps to the tallest frame
      write_csr(REG_LINE_LEN, 16'd3, 1'b1);
      write_csr(REG_LINE_COUNT, 16'd8191, 1'b0);
      send_block(48, FILL_BAND);
      settle();

      // long lines, cut off mid-frame by a new geometry
      write_csr(REG_LINE_LEN, 16'd64, 1'b1);
      write_csr(REG_LINE_COUNT, 16'd5, 1'b0);
      send_block(200, FILL_UNIFORM);
      settle();
      write_csr(REG_LINE_LEN, 16'd5, 1'b1);
      write_csr(REG_LINE_COUNT, 16'd4, 1'b0);
      send_block(7, FILL_EXTREMES);
      settle();

      // writes to unused indexes leave the frame position alone
      write_csr(REG_SPARE_2, 16'hFFFF, 1'b1);
      write_csr(REG_SPARE_3, 16'h0000, 1'b0);
      send_block(33, FILL_UNIFORM);
      settle();

      // random geometries, mostly small, with whole and partial frames
      while (random_sent < RANDOM_ITEMS) begin
         w = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 0) : $urandom_range(12, 3);
         h = ($urandom_range(9, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(8, 3);
         frame = ((w < WIN_SIDE) ? WIN_SIDE : w) * ((h < WIN_SIDE) ? WIN_SIDE : h);
         if ($urandom_range(5, 0) == 0)
            write_csr($urandom_range(1, 0) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom), 1'b1);
         write_csr(REG_LINE_LEN, {5'($urandom), 11'(w)}, 1'b1);
         write_csr(REG_LINE_COUNT, {3'($urandom), 13'(h)}, 1'b0);
         n = ($urandom_range(3, 0) == 0) ? $urandom_range(frame - 1, 1)
                                         : frame * $urandom_range(3, 1);
         gaps_on = ($urandom_range(4, 0) != 0);
         send_block(n, fill_kind_type'($urandom_range(2, 0)));
         random_sent += n;
         settle();
      end

      if (tracker.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
